// ===== design/assert_macros.svh =====
// assertion macros for the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// same-cycle implication, disabled in reset
`define ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
// next-cycle implication, checked during reset too
`define ASSERT_NEXT(label, clk, a, c) \
  label: assert property (@(posedge clk) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// ===== design/hpt_pkg.sv =====
// shared constants and types for the point transform
`default_nettype none
package hpt_pkg;
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned SUM_W = 66;
  localparam int unsigned MAG_W = 65;
  localparam int unsigned QUO_W = 33;
  localparam int unsigned NUM_REGS = 8;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CFG_W = 64;
  localparam int unsigned COORD_W = 32;
  localparam int unsigned LANES = 3;

  typedef struct packed {
    logic             valid;
    logic             wz;
    logic [LANES-1:0] neg;
    logic [LANES-1:0] ov;
  } ctl_t;
endpackage
`default_nettype wire

// ===== design/hpt_xform.sv =====
// matrix multiply, column sums and divider operand preparation
`default_nettype none
module hpt_xform #(
  parameter int unsigned FRAC_BITS = hpt_pkg::FRAC_BITS_DEF,
  localparam int unsigned NW = hpt_pkg::MAG_W + FRAC_BITS,
  localparam int unsigned RW = NW + hpt_pkg::QUO_W + 2
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   en,
  input  wire logic                                   in_valid,
  input  wire logic [3*hpt_pkg::COORD_W-1:0]          in_point,
  input  wire logic [hpt_pkg::NUM_REGS*hpt_pkg::CFG_W-1:0] mat,
  output hpt_pkg::ctl_t                               ctl,
  output logic [hpt_pkg::MAG_W-1:0]                   den,
  output logic [3*NW-1:0]                             num
);
  localparam int unsigned CW = hpt_pkg::COORD_W;
  localparam int unsigned SW = hpt_pkg::SUM_W;

  logic signed [2*CW-1:0] prod [4][3];
  logic signed [CW-1:0]   tr [4];
  logic                   v1, v2;
  logic signed [SW-1:0]   sum [4];
  logic [hpt_pkg::MAG_W-1:0] mag [4];
  logic [NW-1:0]             num_next [3];
  logic [2:0]                ov_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      ctl <= '0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      ctl.valid <= v2;
      ctl.wz <= (sum[3] == '0);
      for (int c = 0; c < 3; c++) begin
        ctl.neg[c] <= sum[c][SW-1] ^ sum[3][SW-1];
      end
      ctl.ov <= ov_next;
    end
  end

  // products of each coordinate with its matrix row, translation row held aside, and column sums
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 4; c++) begin
          prod[c][r] <= $signed(in_point[r*CW +: CW]) *
                        $signed(mat[(r*2 + c/2)*hpt_pkg::CFG_W + (c%2)*CW +: CW]);
        end
      end
      for (int c = 0; c < 4; c++) begin
        tr[c] <= $signed(mat[(6 + c/2)*hpt_pkg::CFG_W + (c%2)*CW +: CW]);
      end
      for (int c = 0; c < 4; c++) begin
        sum[c] <= SW'(prod[c][0]) + SW'(prod[c][1]) + SW'(prod[c][2]) +
                  SW'($signed({tr[c], {FRAC_BITS{1'b0}}}));
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      mag[c] = sum[c][SW-1] ? hpt_pkg::MAG_W'(-sum[c]) : hpt_pkg::MAG_W'(sum[c]);
    end
    for (int c = 0; c < 3; c++) begin
      num_next[c] = {mag[c], {FRAC_BITS{1'b0}}};
      ov_next[c] = RW'(num_next[c]) >= RW'({mag[3], {hpt_pkg::QUO_W{1'b0}}});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den <= mag[3];
      for (int c = 0; c < 3; c++) begin
        num[c*NW +: NW] <= num_next[c];
      end
    end
  end
endmodule
`default_nettype wire

// ===== design/hpt_div_cell.sv =====
// one restoring-division cell: one quotient bit for each of three lanes
`default_nettype none
module hpt_div_cell #(
  parameter int unsigned FRAC_BITS = hpt_pkg::FRAC_BITS_DEF,
  parameter int unsigned SHIFT = 0,
  localparam int unsigned NW = hpt_pkg::MAG_W + FRAC_BITS,
  localparam int unsigned RW = NW + hpt_pkg::QUO_W + 2,
  localparam int unsigned QW = hpt_pkg::QUO_W
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        en,
  input  wire hpt_pkg::ctl_t               ctl_in,
  input  wire logic [hpt_pkg::MAG_W-1:0]   den_in,
  input  wire logic [3*NW-1:0]             rem_in,
  input  wire logic [3*QW-1:0]             quo_in,
  output hpt_pkg::ctl_t                    ctl_out,
  output logic [hpt_pkg::MAG_W-1:0]        den_out,
  output logic [3*NW-1:0]                  rem_out,
  output logic [3*QW-1:0]                  quo_out
);
  logic [RW-1:0] dsh;
  logic [RW-1:0] diff [3];
  logic [2:0]    take;

  always_comb begin
    dsh = RW'(den_in) << SHIFT;
    for (int c = 0; c < 3; c++) begin
      diff[c] = RW'(rem_in[c*NW +: NW]) - dsh;
      take[c] = RW'(rem_in[c*NW +: NW]) >= dsh;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (en) begin
      ctl_out <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_out <= den_in;
      for (int c = 0; c < 3; c++) begin
        rem_out[c*NW +: NW] <= take[c] ? diff[c][NW-1:0] : rem_in[c*NW +: NW];
        quo_out[c*QW +: QW] <= quo_in[c*QW +: QW] | (QW'(take[c]) << SHIFT);
      end
    end
  end
endmodule
`default_nettype wire

// ===== design/homogeneous_point_transform.sv =====
// top level: homogeneous point transform with perspective divide
// Points arrive on the s_ channel, one request per cycle while s_tready
// is high, as x, y, z in signed fixed point. Each point is multiplied by
// the 4x4 matrix held in eight 64-bit registers written over the cfg
// port, and x, y, z sums are divided by w. Results leave on the m_
// channel in arrival order. Each result passes the registered multiply,
// sum and operand prep stages, then a row of 33 divider cells that each
// settle one quotient bit, then the saturating output register.
// Throughput is one point per cycle while the receiver does not stall;
// the divider cell row is fully pipelined.
// When the receiver stalls with a result waiting, the whole pipeline
// holds and s_tready drops; it resumes as soon as the result is taken.
// Reset clears every valid bit and loads the identity matrix.
// tuser bit 0 flags a zero w (outputs zero), bit 1 flags saturation.
// Write the matrix only while no request is in flight.
`default_nettype none
module homogeneous_point_transform #(
  parameter int unsigned FRAC_BITS = hpt_pkg::FRAC_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [95:0]                       s_tdata,  // point_x, point_y, point_z
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic [95:0]                            m_tdata,  // proj_x, proj_y, proj_z
  output logic [1:0]                             m_tuser,  // w_zero, clipped
  input  wire logic                              cfg_we,
  input  wire logic [hpt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [hpt_pkg::CFG_W-1:0]         cfg_data
);
  localparam int unsigned NW = hpt_pkg::MAG_W + FRAC_BITS;
  localparam int unsigned QW = hpt_pkg::QUO_W;
  localparam int unsigned CW = hpt_pkg::COORD_W;
  localparam int unsigned NC = QW;
  localparam int unsigned DW = hpt_pkg::CFG_W;
  localparam logic [DW-1:0] ONE_LO = DW'(1) << FRAC_BITS;
  localparam logic [DW-1:0] ONE_HI = DW'(1) << (FRAC_BITS + CW);

  logic [hpt_pkg::NUM_REGS*DW-1:0] mat;
  logic en;

  assign en = !m_tvalid || m_tready;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      mat <= {ONE_HI, {DW{1'b0}}, ONE_LO, {DW{1'b0}}, {DW{1'b0}}, ONE_HI,
              {DW{1'b0}}, ONE_LO};
    end else if (cfg_we && (cfg_index < hpt_pkg::CFG_IDX_W'(hpt_pkg::NUM_REGS))) begin
      mat[cfg_index[2:0]*DW +: DW] <= cfg_data;
    end
  end

  hpt_pkg::ctl_t             ctl [NC+1];
  logic [hpt_pkg::MAG_W-1:0] den [NC+1];
  logic [3*NW-1:0]           rem [NC+1];
  logic [3*QW-1:0]           quo [NC+1];

  assign quo[0] = '0;

  hpt_xform #(.FRAC_BITS(FRAC_BITS)) u_xform (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(s_tvalid), .in_point(s_tdata), .mat(mat),
    .ctl(ctl[0]), .den(den[0]), .num(rem[0])
  );

  for (genvar k = 0; k < NC; k++) begin : g_cell
    hpt_div_cell #(.FRAC_BITS(FRAC_BITS), .SHIFT(NC - 1 - k)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .ctl_in(ctl[k]), .den_in(den[k]), .rem_in(rem[k]), .quo_in(quo[k]),
      .ctl_out(ctl[k+1]), .den_out(den[k+1]), .rem_out(rem[k+1]),
      .quo_out(quo[k+1])
    );
  end

  hpt_pkg::ctl_t  fc;
  logic [QW-1:0]  q [3];
  logic [2:0]     sat;
  logic [CW-1:0]  res [3];

  assign fc = ctl[NC];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      q[c] = quo[NC][c*QW +: QW];
      if (fc.neg[c]) begin
        sat[c] = fc.ov[c] || (q[c] > QW'(33'h080000000));
        res[c] = sat[c] ? CW'(32'h80000000) : CW'(-q[c]);
      end else begin
        sat[c] = fc.ov[c] || (q[c] > QW'(33'h07fffffff));
        res[c] = sat[c] ? CW'(32'h7fffffff) : q[c][CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= fc.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (fc.wz) begin
        m_tdata <= '0;
        m_tuser <= 2'b01;
      end else begin
        m_tdata <= {res[2], res[1], res[0]};
        m_tuser <= {|sat, 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

// ===== design/hpt_checker.sv =====
// port-level checks for the point transform, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module hpt_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [95:0] m_tdata,
  input wire logic [1:0]  m_tuser
);
  `ASSERT_NEXT(a_rst_idle, clk, rst, !m_tvalid)
  `ASSERT_IMP(a_wz_noclip, clk, rst, m_tvalid && m_tuser[0], !m_tuser[1])
  `ASSERT_IMP(a_wz_zero, clk, rst, m_tvalid && m_tuser[0], m_tdata == '0)
  `ASSERT_IMP(a_ready_free, clk, rst, !m_tvalid || m_tready, s_tready)
endmodule

bind homogeneous_point_transform hpt_checker u_hpt_checker (
  .clk(clk), .rst(rst), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);
`default_nettype wire
